// ===== rtl/imuce_pkg.sv =====
// Package for the IMU complementary attitude estimator.
// Holds fixed-point constants, register indexes and a constant rescale function.
// No dependencies.
`default_nettype none
package imuce_pkg;
  localparam int FracBitsDef = 16;
  localparam logic [1:0] CFG_STEP_TIME    = 2'd0;
  localparam logic [1:0] CFG_GYRO_WEIGHT  = 2'd1;
  localparam logic [1:0] CFG_ACCEL_WEIGHT = 2'd2;

  function automatic logic [31:0] rescale(input logic [31:0] c, input int fb);
    logic [63:0] w;
    w = {32'd0, c} << fb;
    return w[47:16];
  endfunction
endpackage
`default_nettype wire

// ===== rtl/imuce_div.sv =====
// Iterative signed divider: low 32 bits of (a << FRAC_BITS) / b, truncating.
// One quotient bit per cycle. Depends on imuce_pkg.
`default_nettype none
module imuce_div import imuce_pkg::*; #(
  parameter int FRAC_BITS = FracBitsDef
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        start,
  input  wire logic [31:0] num,
  input  wire logic [31:0] den,
  output logic             done,
  output logic [31:0]      quo
);
  localparam int NW = 32 + FRAC_BITS;
  logic [NW-1:0] q_r, q_nxt;
  logic [32:0]   rem_r, rem_nxt;
  logic [31:0]   d_r, d_nxt;
  logic          neg_r, neg_nxt, busy_r, busy_nxt, done_r, done_nxt;
  logic [6:0]    cnt_r, cnt_nxt;
  logic [32:0]   sh, diff;
  logic [NW-1:0] nabs;

  always_comb begin
    q_nxt = q_r; rem_nxt = rem_r; d_nxt = d_r; neg_nxt = neg_r;
    busy_nxt = busy_r; cnt_nxt = cnt_r; done_nxt = 1'b0;
    nabs = '0;
    sh = {rem_r[31:0], q_r[NW-1]};
    diff = sh - {1'b0, d_r};
    if (start) begin
      nabs = {{FRAC_BITS{1'b0}}, (num[31] ? (~num + 32'd1) : num)} << FRAC_BITS;
      q_nxt = nabs;
      rem_nxt = '0;
      d_nxt = den[31] ? (~den + 32'd1) : den;
      neg_nxt = num[31] ^ den[31];
      cnt_nxt = 7'(NW);
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      if (!diff[32]) begin
        rem_nxt = diff;
        q_nxt = {q_r[NW-2:0], 1'b1};
      end else begin
        rem_nxt = sh;
        q_nxt = {q_r[NW-2:0], 1'b0};
      end
      cnt_nxt = cnt_r - 7'd1;
      if (cnt_r == 7'd1) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0; done_r <= 1'b0; cnt_r <= '0;
    end else begin
      busy_r <= busy_nxt; done_r <= done_nxt; cnt_r <= cnt_nxt;
    end
    q_r <= q_nxt; rem_r <= rem_nxt; d_r <= d_nxt; neg_r <= neg_nxt;
  end

  assign done = done_r;
  assign quo = neg_r ? (~q_r[31:0] + 32'd1) : q_r[31:0];
endmodule
`default_nettype wire

// ===== rtl/imu_complementary_attitude_estimator.sv =====
// Complementary-filter attitude estimator over one shared 32x32 multiplier.
// Each result runs through the single multiplier and, unless Az is zero, the
// bit-serial divider; values are Q16.16 for the default FRAC_BITS. One
// request at a time: a new request is taken only after the previous result
// has been accepted, so a stalled result also holds off new input.
// Reset restores default weights and step time; zeroes angle/vel/pos state.
`default_nettype none
module imu_complementary_attitude_estimator import imuce_pkg::*; #(
  parameter int FRAC_BITS = FracBitsDef
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire logic signed [15:0] in_accel_x_raw,
  input  wire logic signed [15:0] in_accel_y_raw,
  input  wire logic signed [15:0] in_accel_z_raw,
  input  wire logic signed [15:0] in_gyro_x_raw,
  input  wire logic signed [15:0] in_gyro_y_raw,
  input  wire logic signed [15:0] in_gyro_z_raw,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output logic signed [31:0]      out_roll_angle,
  output logic signed [31:0]      out_pitch_angle,
  output logic signed [31:0]      out_yaw_angle,
  output logic signed [31:0]      out_roll_rate,
  output logic signed [31:0]      out_pitch_rate,
  output logic signed [31:0]      out_yaw_rate,
  output logic signed [31:0]      out_velocity_x,
  output logic signed [31:0]      out_velocity_y,
  output logic signed [31:0]      out_velocity_z,
  output logic signed [31:0]      out_position_x,
  output logic signed [31:0]      out_position_y,
  output logic signed [31:0]      out_position_z,
  input  wire logic               cfg_we,
  input  wire logic [1:0]         cfg_index,
  input  wire logic [16:0]        cfg_data
);
  localparam logic [31:0] KAccel = rescale(32'd16, FRAC_BITS);
  localparam logic [31:0] KGrav  = rescale(32'd643048, FRAC_BITS);
  localparam logic [31:0] KGyro  = rescale(32'd4005, FRAC_BITS);
  localparam logic [31:0] KR2D   = rescale(32'd3754967, FRAC_BITS);
  localparam logic [31:0] RstStep = rescale(32'd131, FRAC_BITS);
  localparam logic [31:0] RstGw   = rescale(32'd64225, FRAC_BITS);
  localparam logic [31:0] RstAw   = rescale(32'd1311, FRAC_BITS);

  localparam logic [2:0] S_IDLE = 3'd0, S_MUL = 3'd1, S_DIVW = 3'd2, S_OUT = 3'd3;

  // Register file: 0-5 raw scaled inputs -> ax ay az wr wp wy, 6 acc_roll,
  // 7 acc_pitch, 8 tmp, 9-11 roll pitch yaw, 12-14 vel, 15-17 pos.
  logic [31:0] rf_r [18];
  logic [31:0] rf_nxt [18];
  logic [15:0] step_r;
  logic [16:0] gw_r, aw_r;
  logic [2:0]  st_r, st_nxt;
  logic [5:0]  pc_r, pc_nxt;
  logic        dsel_r, dsel_nxt;
  logic        dstart;
  logic [31:0] dnum;
  logic        ddone;
  logic [31:0] dquo;

  logic [31:0] ma, mb;
  logic signed [63:0] prod;
  logic [31:0] mres;

  imuce_div #(.FRAC_BITS(FRAC_BITS)) u_div (
    .clk(clk), .rst_n(rst_n), .start(dstart), .num(dnum), .den(rf_r[2]),
    .done(ddone), .quo(dquo)
  );

  function automatic logic [31:0] rawfx(input logic [15:0] v);
    return 32'({{16{v[15]}}, v} << FRAC_BITS);
  endfunction

  logic [31:0] dtw, gww, aww;
  assign dtw = {16'd0, step_r};
  assign gww = {15'd0, gw_r};
  assign aww = {15'd0, aw_r};

  // Microprogram: operand select per step, then result written.
  always_comb begin
    ma = rf_r[0]; mb = KAccel;
    unique case (pc_r)
      6'd0:  begin ma = rf_r[0];  mb = KAccel; end
      6'd1:  begin ma = rf_r[0];  mb = KGrav;  end
      6'd2:  begin ma = rf_r[1];  mb = KAccel; end
      6'd3:  begin ma = rf_r[1];  mb = KGrav;  end
      6'd4:  begin ma = rf_r[2];  mb = KAccel; end
      6'd5:  begin ma = rf_r[2];  mb = KGrav;  end
      6'd6:  begin ma = rf_r[3];  mb = KGyro;  end
      6'd7:  begin ma = rf_r[4];  mb = KGyro;  end
      6'd8:  begin ma = rf_r[5];  mb = KGyro;  end
      6'd9:  begin ma = rf_r[6];  mb = KR2D;   end
      6'd10: begin ma = rf_r[7];  mb = KR2D;   end
      6'd11: begin ma = rf_r[9];  mb = gww;    end
      6'd12: begin ma = rf_r[6];  mb = aww;    end
      6'd13: begin ma = rf_r[3];  mb = dtw;    end
      6'd14: begin ma = rf_r[10]; mb = gww;    end
      6'd15: begin ma = rf_r[7];  mb = aww;    end
      6'd16: begin ma = rf_r[4];  mb = dtw;    end
      6'd17: begin ma = rf_r[5];  mb = dtw;    end
      6'd18: begin ma = rf_r[0];  mb = dtw;    end
      6'd19: begin ma = rf_r[1];  mb = dtw;    end
      6'd20: begin ma = rf_r[2];  mb = dtw;    end
      6'd21: begin ma = rf_r[12]; mb = dtw;    end
      6'd22: begin ma = rf_r[13]; mb = dtw;    end
      6'd23: begin ma = rf_r[14]; mb = dtw;    end
      default: begin ma = rf_r[0]; mb = KAccel; end
    endcase
    prod = $signed(ma) * $signed(mb);
    mres = prod[FRAC_BITS +: 32];
  end

  always_comb begin
    for (int i = 0; i < 18; i++) rf_nxt[i] = rf_r[i];
    st_nxt = st_r; pc_nxt = pc_r; dsel_nxt = dsel_r;
    dstart = 1'b0;
    dnum = dsel_r ? rf_r[0] : rf_r[1];
    unique case (st_r)
      S_IDLE: begin
        if (in_valid) begin
          rf_nxt[0] = rawfx(in_accel_x_raw);
          rf_nxt[1] = rawfx(in_accel_y_raw);
          rf_nxt[2] = rawfx(in_accel_z_raw);
          rf_nxt[3] = rawfx(in_gyro_x_raw);
          rf_nxt[4] = rawfx(in_gyro_y_raw);
          rf_nxt[5] = rawfx(in_gyro_z_raw);
          pc_nxt = 6'd0;
          st_nxt = S_MUL;
        end
      end
      S_MUL: begin
        pc_nxt = pc_r + 6'd1;
        unique case (pc_r)
          6'd0, 6'd1: rf_nxt[0] = mres;
          6'd2, 6'd3: rf_nxt[1] = mres;
          6'd4, 6'd5: rf_nxt[2] = mres;
          6'd6: rf_nxt[3] = mres;
          6'd7: rf_nxt[4] = mres;
          6'd8: begin
            rf_nxt[5] = mres;
            if (rf_r[2] != 32'd0) begin
              dstart = 1'b1; dsel_nxt = 1'b0; st_nxt = S_DIVW;
              dnum = rf_r[1];
            end else begin
              rf_nxt[6] = rf_r[9]; rf_nxt[7] = rf_r[10]; pc_nxt = 6'd11;
            end
          end
          6'd9: rf_nxt[6] = mres;
          6'd10: rf_nxt[7] = mres;
          6'd11, 6'd14: rf_nxt[8] = mres;
          6'd12: rf_nxt[8] = rf_r[8] + mres;
          6'd13: rf_nxt[9] = rf_r[8] + mres;
          6'd15: rf_nxt[8] = rf_r[8] + mres;
          6'd16: rf_nxt[10] = rf_r[8] + mres;
          6'd17: rf_nxt[11] = rf_r[11] + mres;
          6'd18: rf_nxt[12] = rf_r[12] + mres;
          6'd19: rf_nxt[13] = rf_r[13] + mres;
          6'd20: rf_nxt[14] = rf_r[14] + mres;
          6'd21: rf_nxt[15] = rf_r[15] + mres;
          6'd22: rf_nxt[16] = rf_r[16] + mres;
          6'd23: begin rf_nxt[17] = rf_r[17] + mres; st_nxt = S_OUT; end
          default: st_nxt = S_OUT;
        endcase
      end
      S_DIVW: begin
        if (ddone) begin
          if (!dsel_r) begin
            rf_nxt[6] = dquo; dsel_nxt = 1'b1; dstart = 1'b1;
            dnum = rf_r[0];
          end else begin
            rf_nxt[7] = dquo; st_nxt = S_MUL; pc_nxt = 6'd9;
          end
        end
      end
      S_OUT: if (!out_stall) st_nxt = S_IDLE;
      default: st_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= S_IDLE; pc_r <= '0; dsel_r <= 1'b0;
      step_r <= RstStep[15:0]; gw_r <= RstGw[16:0]; aw_r <= RstAw[16:0];
      for (int i = 9; i < 18; i++) rf_r[i] <= '0;
    end else begin
      st_r <= st_nxt; pc_r <= pc_nxt; dsel_r <= dsel_nxt;
      for (int i = 9; i < 18; i++) rf_r[i] <= rf_nxt[i];
      if (cfg_we) begin
        unique case (cfg_index)
          CFG_STEP_TIME:    step_r <= cfg_data[15:0];
          CFG_GYRO_WEIGHT:  gw_r <= cfg_data;
          CFG_ACCEL_WEIGHT: aw_r <= cfg_data;
          default: ;
        endcase
      end
    end
    for (int i = 0; i < 9; i++) rf_r[i] <= rf_nxt[i];
  end

  assign in_stall = (st_r != S_IDLE);
  assign out_valid = (st_r == S_OUT);
  assign out_roll_angle = rf_r[9];
  assign out_pitch_angle = rf_r[10];
  assign out_yaw_angle = rf_r[11];
  assign out_roll_rate = rf_r[3];
  assign out_pitch_rate = rf_r[4];
  assign out_yaw_rate = rf_r[5];
  assign out_velocity_x = rf_r[12];
  assign out_velocity_y = rf_r[13];
  assign out_velocity_z = rf_r[14];
  assign out_position_x = rf_r[15];
  assign out_position_y = rf_r[16];
  assign out_position_z = rf_r[17];
endmodule
`default_nettype wire

// ===== test/imu_complementary_attitude_estimator_test.sv =====
// Testbench for the IMU complementary attitude estimator: drives raw six-axis
// samples, predicts each attitude/velocity/position result and checks it.
// Depends on imuce_pkg and the imu_complementary_attitude_estimator RTL.
module imu_complementary_attitude_estimator_test import imuce_pkg::*;;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int FB = FracBitsDef;
  localparam logic [31:0] K_ACCEL = 32'd16;
  localparam logic [31:0] K_GRAV = 32'd643048;
  localparam logic [31:0] K_GYRO = 32'd4005;
  localparam logic [31:0] K_DEG = 32'd3754967;
  localparam logic [1:0] CFG_UNUSED = 2'd3;
  localparam int SETTLE = 200;
  localparam int CYCLE_LIMIT = 2000000;

  typedef struct packed {
    logic [31:0] roll, pitch, yaw, wr, wp, wy, vx, vy, vz, px, py, pz;
  } attitude_t;

  logic clk = 0;
  logic rst_n = 0;
  logic in_valid = 0;
  logic in_stall;
  logic signed [15:0] in_ax = 0, in_ay = 0, in_az = 0, in_gx = 0, in_gy = 0, in_gz = 0;
  logic out_valid;
  logic out_stall = 0;
  wire attitude_t got;
  logic cfg_we = 0;
  logic [1:0] cfg_index = 0;
  logic [16:0] cfg_data = 0;

  logic [31:0] step_time, gyro_weight, accel_weight;
  logic [31:0] roll_est, pitch_est, yaw_est, vel[3], pos[3];
  attitude_t pending_attitudes[$];
  int mismatches = 0;
  int cycles = 0;
  int idle_pct = 21;

  imu_complementary_attitude_estimator DUT (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall),
    .in_accel_x_raw(in_ax), .in_accel_y_raw(in_ay), .in_accel_z_raw(in_az),
    .in_gyro_x_raw(in_gx), .in_gyro_y_raw(in_gy), .in_gyro_z_raw(in_gz),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_roll_angle(got.roll), .out_pitch_angle(got.pitch), .out_yaw_angle(got.yaw),
    .out_roll_rate(got.wr), .out_pitch_rate(got.wp), .out_yaw_rate(got.wy),
    .out_velocity_x(got.vx), .out_velocity_y(got.vy), .out_velocity_z(got.vz),
    .out_position_x(got.px), .out_position_y(got.py), .out_position_z(got.pz),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always begin
    #6 clk = 1;
    #6 clk = 0;
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  function automatic logic [31:0] qmul(logic [31:0] a, logic [31:0] b);
    logic signed [63:0] p;
    p = $signed(a) * $signed(b);
    p = p >>> FB;
    return p[31:0];
  endfunction

  function automatic logic [31:0] qdiv(logic [31:0] a, logic [31:0] b);
    logic signed [63:0] n, q;
    n = $signed(a);
    n = n <<< FB;
    q = n / $signed({{32{b[31]}}, b});
    return q[31:0];
  endfunction

  function automatic logic [31:0] to_fixed(logic [15:0] r);
    logic [31:0] s;
    s = {{16{r[15]}}, r};
    return s << FB;
  endfunction

  function automatic logic [31:0] accel_si(logic [15:0] r);
    return qmul(qmul(to_fixed(r), K_ACCEL), K_GRAV);
  endfunction

  function automatic attitude_t update_attitude(logic [15:0] r[6]);
    attitude_t e;
    logic [31:0] a[3], ar, ap, w[3];
    for (int i = 0; i < 3; i++) begin
      a[i] = accel_si(r[i]);
      w[i] = qmul(to_fixed(r[i + 3]), K_GYRO);
    end
    if (a[2] != 0) begin
      ar = qmul(qdiv(a[1], a[2]), K_DEG);
      ap = qmul(qdiv(a[0], a[2]), K_DEG);
    end else begin
      ar = roll_est;
      ap = pitch_est;
    end
    roll_est = qmul(roll_est, gyro_weight) + qmul(ar, accel_weight) + qmul(w[0], step_time);
    pitch_est = qmul(pitch_est, gyro_weight) + qmul(ap, accel_weight) + qmul(w[1], step_time);
    yaw_est = yaw_est + qmul(w[2], step_time);
    for (int i = 0; i < 3; i++) begin
      vel[i] = vel[i] + qmul(a[i], step_time);
      pos[i] = pos[i] + qmul(vel[i], step_time);
    end
    e = '{roll_est, pitch_est, yaw_est, w[0], w[1], w[2],
          vel[0], vel[1], vel[2], pos[0], pos[1], pos[2]};
    return e;
  endfunction

  always @(posedge clk) begin
    attitude_t e;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_attitudes.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("Unexpected result %h", got);
      end else begin
        e = pending_attitudes.pop_front();
        if (e !== got) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("Mismatch roll %h/%h pitch %h/%h yaw %h/%h", e.roll, got.roll,
                     e.pitch, got.pitch, e.yaw, got.yaw);
            $display("  rates %h %h %h / %h %h %h", e.wr, e.wp, e.wy, got.wr, got.wp, got.wy);
            $display("  vel %h %h %h / %h %h %h", e.vx, e.vy, e.vz, got.vx, got.vy, got.vz);
            $display("  pos %h %h %h / %h %h %h", e.px, e.py, e.pz, got.px, got.py, got.pz);
          end
        end
      end
    end
    out_stall <= ($urandom_range(99) < idle_pct);
  end

  task automatic send_sample(logic [15:0] r[6]);
    while ($urandom_range(99) < idle_pct) begin
      in_valid <= 0;
      @(posedge clk);
    end
    in_valid <= 1;
    {in_ax, in_ay, in_az, in_gx, in_gy, in_gz} <= {r[0], r[1], r[2], r[3], r[4], r[5]};
    pending_attitudes.push_back(update_attitude(r));
    do @(posedge clk); while (in_stall);
  endtask

  task automatic drain();
    in_valid <= 0;
    while (pending_attitudes.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [16:0] v);
    cfg_we <= 1;
    cfg_index <= idx;
    cfg_data <= v;
    @(posedge clk);
    cfg_we <= 0;
    @(posedge clk);
    if (idx == CFG_STEP_TIME) step_time = v[15:0];
    else if (idx == CFG_GYRO_WEIGHT) gyro_weight = v;
    else if (idx == CFG_ACCEL_WEIGHT) accel_weight = v;
  endtask

  task automatic set_filter(logic [16:0] st, logic [16:0] gw, logic [16:0] aw);
    drain();
    write_reg(CFG_STEP_TIME, st);
    write_reg(CFG_GYRO_WEIGHT, gw);
    write_reg(CFG_ACCEL_WEIGHT, aw);
  endtask

  task automatic random_sample(int mode);
    logic [15:0] r[6];
    for (int i = 0; i < 6; i++) r[i] = 16'($urandom);
    if (mode == 1) begin
      r[0] = 16'($urandom_range(8191) - 4096);
      r[1] = 16'($urandom_range(8191) - 4096);
      r[2] = 16'(4096 + $urandom_range(400) - 200);
      for (int i = 3; i < 6; i++) r[i] = 16'($urandom_range(2047) - 1024);
    end else if (mode == 2) begin
      r[2] = 0;
    end
    send_sample(r);
  endtask

  task automatic test_extremes();
    logic [15:0] v[5] = '{16'h8000, 16'h7fff, 16'h0000, 16'hffff, 16'h0001};
    logic [15:0] r[6];
    for (int k = 0; k < 5; k++) begin
      for (int i = 0; i < 6; i++) r[i] = v[(k + i) % 5];
      send_sample(r);
    end
    r = '{16'h7fff, 16'h8000, 16'h0001, 16'h7fff, 16'h8000, 16'h7fff};
    send_sample(r);
    r = '{16'h8000, 16'h7fff, 16'hffff, 16'h8000, 16'h7fff, 16'h8000};
    send_sample(r);
    r = '{16'h8000, 16'h8000, 16'h8000, 16'h0, 16'h0, 16'h0};
    send_sample(r);
    r = '{16'h1000, 16'h1000, 16'h0, 16'h10, 16'h20, 16'h30};
    send_sample(r);
    r = '{16'h1000, 16'h1000, 16'h1000, 16'h10, 16'h20, 16'h30};
    send_sample(r);
  endtask

  task automatic test_register_settings();
    set_filter(17'd0, 17'd65536, 17'd0);
    for (int i = 0; i < 10; i++) random_sample(i % 3);
    set_filter(17'd65535, 17'd0, 17'd65536);
    for (int i = 0; i < 10; i++) random_sample(i % 3);
    drain();
    write_reg(CFG_UNUSED, 17'h1ffff);
    set_filter(17'd131, 17'h1ffff, 17'h1ffff);
    for (int i = 0; i < 5; i++) random_sample(i % 3);
  endtask

  task automatic test_random_stream();
    set_filter(17'd131, 17'd64225, 17'd1311);
    for (int i = 0; i < 600; i++) begin
      idle_pct = (i >= 250 && i < 350) ? 0 : 21;
      if (i % 150 == 149)
        set_filter(17'($urandom_range(65535)), 17'($urandom_range(65536)),
                   17'($urandom_range(65536)));
      random_sample($urandom_range(99) < 70 ? 1 : ($urandom_range(9) == 0 ? 2 : 0));
    end
  endtask

  initial begin
    step_time = 131;
    gyro_weight = 64225;
    accel_weight = 1311;
    {roll_est, pitch_est, yaw_est} = '0;
    for (int i = 0; i < 3; i++) begin
      vel[i] = 0;
      pos[i] = 0;
    end
    repeat (5) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);
    test_extremes();
    test_register_settings();
    test_random_stream();
    drain();
    if (mismatches == 0 && pending_attitudes.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end
endmodule
